[hdl/positional_list_engine_unit_defines.svh]
// assertion macros shared by the checker of the positional list engine
`ifndef POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, quiet during reset
`define PLE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// next-cycle implication, sampled on the rising clock edge, quiet during reset
`define PLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

[hdl/ple_pkg.sv]
// shared constants, codes and control types of the positional list engine
package ple_pkg;

    localparam int CAPACITY   = 32;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LEN_W      = $clog2(CAPACITY + 1);
    localparam int FUNC_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 6;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 6;
    localparam int ITEM_W     = 32;
    localparam int POS_W      = ((LEN_W > POSITION_W) ? LEN_W : POSITION_W) + 1;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_DUMP      = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_dump;
        logic list_empty;
        logic out_free;
        logic dump_last;
    } dp_stat_t;

endpackage

[hdl/ple_ctrl.sv]
// command sequencer of the positional list engine
module ple_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output ple_pkg::ctrl_cmd_t  cmd,
    input  ple_pkg::dp_stat_t   stat
);
    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // a non-empty dump streams elements, everything else gives one result
                if (stat.is_dump && !stat.list_empty)
                begin
                    state_next = S_DUMP;
                end
                else if (stat.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/ple_dpath.sv]
// cell chain, entry count, command register and result register of the list engine
module ple_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ple_pkg::FUNC_W-1:0]      func,
    input  logic [ple_pkg::VALUE_W-1:0]     value,
    input  logic [ple_pkg::POSITION_W-1:0]  position,
    input  ple_pkg::ctrl_cmd_t              cmd,
    output ple_pkg::dp_stat_t               stat,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ple_pkg::STATUS_W-1:0]    status,
    output logic [ple_pkg::COUNT_W-1:0]     count,
    output logic [ple_pkg::ITEM_W-1:0]      item,
    output logic                            item_valid,
    output logic                            last
);
    import ple_pkg::*;

    // command register
    func_t                  func_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [POSITION_W-1:0]  pos_reg;

    // list storage
    logic [DATA_WIDTH-1:0]  cell_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_next [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_up   [CAPACITY];
    logic [DATA_WIDTH-1:0]  cell_down [CAPACITY];
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       len_next;
    logic [IDX_W-1:0]       idx_reg;
    logic [IDX_W-1:0]       idx_next;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    status_t                status_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [ITEM_W-1:0]      item_reg;
    logic                   item_valid_reg;
    logic                   last_reg;

    logic                   is_ins;
    logic                   is_del;
    logic                   is_dump;
    logic [POS_W-1:0]       pos_sel;
    logic [POS_W-1:0]       len_ext;
    status_t                exec_status;
    logic                   do_ins;
    logic                   do_del;
    logic [IDX_W-1:0]       shift_idx;
    logic                   out_load;

    assign len_ext = POS_W'(len_reg);

    // decode the held command
    always_comb
    begin
        is_ins  = 1'b0;
        is_del  = 1'b0;
        is_dump = 1'b0;
        pos_sel = POS_W'(1);
        case (func_reg)
            FN_INS_FRONT:
            begin
                is_ins  = 1'b1;
                pos_sel = POS_W'(1);
            end
            FN_INS_BACK:
            begin
                is_ins  = 1'b1;
                pos_sel = len_ext + POS_W'(1);
            end
            FN_INS_POS:
            begin
                is_ins  = 1'b1;
                pos_sel = POS_W'(pos_reg);
            end
            FN_DEL_FRONT:
            begin
                is_del  = 1'b1;
                pos_sel = POS_W'(1);
            end
            FN_DEL_BACK:
            begin
                is_del  = 1'b1;
                pos_sel = len_ext;
            end
            FN_DEL_POS:
            begin
                is_del  = 1'b1;
                pos_sel = POS_W'(pos_reg);
            end
            FN_DUMP:
            begin
                is_dump = 1'b1;
            end
            default:
            begin
                pos_sel = POS_W'(1);
            end
        endcase
    end

    // full and empty are checked ahead of the position range
    always_comb
    begin
        exec_status = ST_OK;
        if (is_ins)
        begin
            if (len_reg >= LEN_W'(CAPACITY))
            begin
                exec_status = ST_FULL;
            end
            else if (pos_sel == '0 || pos_sel > len_ext + POS_W'(1))
            begin
                exec_status = ST_BAD_POS;
            end
        end
        else if (is_del)
        begin
            if (len_reg == '0)
            begin
                exec_status = ST_EMPTY;
            end
            else if (pos_sel == '0 || pos_sel > len_ext)
            begin
                exec_status = ST_BAD_POS;
            end
        end
        else if (is_dump && len_reg == '0)
        begin
            exec_status = ST_EMPTY;
        end
    end

    assign do_ins    = cmd.exec && is_ins && exec_status == ST_OK;
    assign do_del    = cmd.exec && is_del && exec_status == ST_OK;
    assign shift_idx = IDX_W'(pos_sel - POS_W'(1));

    // neighbour taps of the chain
    always_comb
    begin
        cell_up[0]            = cell_reg[0];
        cell_down[CAPACITY-1] = cell_reg[CAPACITY-1];
        for (int i = 1; i < CAPACITY; i++)
        begin
            cell_up[i] = cell_reg[i-1];
        end
        for (int i = 0; i < CAPACITY - 1; i++)
        begin
            cell_down[i] = cell_reg[i+1];
        end
    end

    // every cell above the slot shifts at once; a delete also overwrites the slot itself
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins)
            begin
                if (IDX_W'(i) == shift_idx)
                begin
                    cell_next[i] = DATA_WIDTH'(value_reg);
                end
                else if (IDX_W'(i) > shift_idx)
                begin
                    cell_next[i] = cell_up[i];
                end
            end
            else if (do_del)
            begin
                if (IDX_W'(i) >= shift_idx)
                begin
                    cell_next[i] = cell_down[i];
                end
            end
        end
    end

    always_comb
    begin
        len_next = len_reg;
        if (do_ins)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        else if (do_del)
        begin
            len_next = len_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.emit)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign out_load = cmd.exec || cmd.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func_t'(func);
            value_reg <= value;
            pos_reg   <= position;
        end
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
        if (cmd.exec)
        begin
            status_reg     <= exec_status;
            count_reg      <= COUNT_W'(len_next);
            item_reg       <= '0;
            item_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit)
        begin
            status_reg     <= ST_OK;
            count_reg      <= COUNT_W'(len_reg);
            item_reg       <= ITEM_W'(cell_reg[idx_reg]);
            item_valid_reg <= 1'b1;
            last_reg       <= stat.dump_last;
        end
    end

    assign stat.is_dump    = is_dump;
    assign stat.list_empty = (len_reg == '0);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.dump_last  = (POS_W'(idx_reg) + POS_W'(1) == len_ext);

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = count_reg;
    assign item       = item_reg;
    assign item_valid = item_valid_reg;
    assign last       = last_reg;

endmodule

[hdl/positional_list_engine_unit.sv]
// Positional list engine: an ordered list of up to CAPACITY words held in a chain of registers
// with an entry count. Commands arrive on func/value/position and results leave through a
// registered output stage. A command is taken in the idle state and executed in the next,
// so inserts, deletes and the reserved code give one result each; the whole chain shifts in the
// execute cycle. A dump of a non-empty list spends its execute cycle turning to the dump
// state and then emits one element per cycle through the output register while that register
// is free; an empty list gives a single result. A full output register held by out_stall holds
// the engine back. in_stall is high from the cycle after a transfer until the command's last
// result is in the output register.
module positional_list_engine_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ple_pkg::FUNC_W-1:0]      func,
    input  logic [ple_pkg::VALUE_W-1:0]     value,
    input  logic [ple_pkg::POSITION_W-1:0]  position,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ple_pkg::STATUS_W-1:0]    status,
    output logic [ple_pkg::COUNT_W-1:0]     count,
    output logic [ple_pkg::ITEM_W-1:0]      item,
    output logic                            item_valid,
    output logic                            last
);
    import ple_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    ple_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .value      (value),
        .position   (position),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .count      (count),
        .item       (item),
        .item_valid (item_valid),
        .last       (last)
    );

endmodule

[hdl/ple_checker.sv]
// port-level checks of the positional list engine and their binding
`include "positional_list_engine_unit_defines.svh"

module ple_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [ple_pkg::STATUS_W-1:0]    status,
    input  logic [ple_pkg::ITEM_W-1:0]      item,
    input  logic                            item_valid,
    input  logic                            last
);
    import ple_pkg::*;

    // a held result stays offered
    `PLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // one command at a time: busy right after a transfer in
    `PLE_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
    // only dump elements can be followed by more results
    `PLE_ASSERT_NOW(a_more_is_dump, out_valid && !last, item_valid)
    // no element means a zero item
    `PLE_ASSERT_NOW(a_item_zero, out_valid && !item_valid, item == '0)
    // dump elements always carry an ok status
    `PLE_ASSERT_NOW(a_elem_ok, out_valid && item_valid, status == ST_OK)

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .item       (item),
    .item_valid (item_valid),
    .last       (last)
);
